// ===== src/env_sensor_compensation_unit_macros.svh =====
// Assertion macros shared by the compensation unit RTL.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define ESCU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("escu assertion failed");

// Next-cycle implication.
`define ESCU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("escu assertion failed");

`endif

// ===== src/escu_pkg.sv =====
// Shared constants for the environmental sensor compensation unit.
// No dependencies; used by the top level and the divider.
package escu_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned StepWidth = 6;

   // Quantity codes
   localparam logic [1:0] OP_TEMP  = 2'd0;
   localparam logic [1:0] OP_PRESS = 2'd1;
   localparam logic [1:0] OP_HUM   = 2'd2;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_TEMP    = 3'd0;
   localparam logic [2:0] CSR_PRESS_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_C = 3'd3;
   localparam logic [2:0] CSR_HUM     = 3'd4;

   // Shared unit operations
   localparam logic [2:0] ALU_ADD  = 3'd0;
   localparam logic [2:0] ALU_SUB  = 3'd1;
   localparam logic [2:0] ALU_MUL  = 3'd2;
   localparam logic [2:0] ALU_SDIV = 3'd3;
   localparam logic [2:0] ALU_USHR = 3'd4;

   // Destination registers
   localparam logic [3:0] DST_NONE = 4'd0;
   localparam logic [3:0] DST_A    = 4'd1;
   localparam logic [3:0] DST_B    = 4'd2;
   localparam logic [3:0] DST_C    = 4'd3;
   localparam logic [3:0] DST_D    = 4'd4;
   localparam logic [3:0] DST_E    = 4'd5;
   localparam logic [3:0] DST_P    = 4'd6;
   localparam logic [3:0] DST_Q    = 4'd7;
   localparam logic [3:0] DST_FT   = 4'd8;

   // Step kinds
   localparam logic [1:0] K_ALU  = 2'd0;
   localparam logic [1:0] K_FIN  = 2'd1;
   localparam logic [1:0] K_DIV  = 2'd2;
   localparam logic [1:0] K_ZCHK = 2'd3;

endpackage

// ===== src/env_sensor_compensation_unit.sv =====
// Top level of the environmental sensor compensation unit.
// Depends on escu_pkg, escu_div and env_sensor_compensation_unit_macros.svh.
//
// One transaction on req carries an opcode in tuser and a raw reading in tdata; the unit
// returns one compensated value on rsp. Each item runs as a sequence of steps through one
// shared add/multiply/shift unit; pressure also uses the bit-serial divider. The unit takes one
// item at a time and is not ready while an item is in progress. A temperature item also
// stores the fine temperature used by later pressure and humidity items.
module env_sensor_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] raw_reading, [23:20] zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [17:0] value, [23:18] zero
   output logic [2:0]  rsp_tuser,   // [1:0] quantity, [2] divisor_fault
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import escu_pkg::*;
   `include "env_sensor_compensation_unit_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DIVW = 2'd2;

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff, cal_hum_ff;
   logic [15:0] cal_press_c_ff;

   logic [1:0]  state_ff, state_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [1:0]  op_ff;
   logic [19:0] raw_ff;
   logic [31:0] ra_ff, rb_ff, rc_ff, rd_ff, re_ff, rp_ff, rq_ff, ft_ff;
   logic        rsp_valid_ff;
   logic [17:0] rsp_value_ff;
   logic [1:0]  rsp_qty_ff;
   logic        rsp_fault_ff;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [31:0] h1, h2, h3, h4, h5, h6;
   logic [2:0]  alu_op;
   logic [4:0]  alu_sh;
   logic [31:0] alu_a, alu_b, alu_res;
   logic [3:0]  dst;
   logic [1:0]  kind;
   logic [63:0] mul_full;
   logic [31:0] sdiv_bias;
   logic [31:0] fin_value;
   logic        out_free;
   logic        div_start, div_busy, div_done;
   logic [31:0] div_quot;
   logic [31:0] hum_clip;

   // Calibration words, sign or zero extended
   assign t1 = {16'b0, cal_temp_ff[15:0]};
   assign t2 = {{16{cal_temp_ff[31]}}, cal_temp_ff[31:16]};
   assign t3 = {{16{cal_temp_ff[47]}}, cal_temp_ff[47:32]};
   assign p1 = {16'b0, cal_press_a_ff[15:0]};
   assign p2 = {{16{cal_press_a_ff[31]}}, cal_press_a_ff[31:16]};
   assign p3 = {{16{cal_press_a_ff[47]}}, cal_press_a_ff[47:32]};
   assign p4 = {{16{cal_press_a_ff[63]}}, cal_press_a_ff[63:48]};
   assign p5 = {{16{cal_press_b_ff[15]}}, cal_press_b_ff[15:0]};
   assign p6 = {{16{cal_press_b_ff[31]}}, cal_press_b_ff[31:16]};
   assign p7 = {{16{cal_press_b_ff[47]}}, cal_press_b_ff[47:32]};
   assign p8 = {{16{cal_press_b_ff[63]}}, cal_press_b_ff[63:48]};
   assign p9 = {{16{cal_press_c_ff[15]}}, cal_press_c_ff};
   assign h1 = {24'b0, cal_hum_ff[7:0]};
   assign h2 = {{16{cal_hum_ff[23]}}, cal_hum_ff[23:8]};
   assign h3 = {24'b0, cal_hum_ff[31:24]};
   assign h4 = {{20{cal_hum_ff[43]}}, cal_hum_ff[43:32]};
   assign h5 = {{20{cal_hum_ff[55]}}, cal_hum_ff[55:44]};
   assign h6 = {{24{cal_hum_ff[63]}}, cal_hum_ff[63:56]};

   // Step program: operands, operation and destination for the current step.
   always_comb begin
      alu_op = ALU_ADD;
      alu_sh = 5'd0;
      alu_a  = '0;
      alu_b  = '0;
      dst    = DST_NONE;
      kind   = K_FIN;
      case (op_ff)
         OP_TEMP: begin
            kind = K_ALU;
            case (step_ff)
               6'd0: begin alu_op = ALU_SUB; alu_a = {15'b0, raw_ff[19:3]};
                  alu_b = {t1[30:0], 1'b0}; dst = DST_A; end
               6'd1: begin alu_op = ALU_MUL; alu_a = ra_ff; alu_b = t2; dst = DST_A; end
               6'd2: begin alu_op = ALU_SDIV; alu_a = ra_ff; alu_sh = 5'd11; dst = DST_A; end
               6'd3: begin alu_op = ALU_SUB; alu_a = {16'b0, raw_ff[19:4]}; alu_b = t1;
                  dst = DST_B; end
               6'd4: begin alu_op = ALU_MUL; alu_a = rb_ff; alu_b = rb_ff; dst = DST_B; end
               6'd5: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd12; dst = DST_B; end
               6'd6: begin alu_op = ALU_MUL; alu_a = rb_ff; alu_b = t3; dst = DST_B; end
               6'd7: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd14; dst = DST_B; end
               6'd8: begin alu_op = ALU_ADD; alu_a = ra_ff; alu_b = rb_ff; dst = DST_FT; end
               6'd9: begin alu_op = ALU_MUL; alu_a = ft_ff; alu_b = 32'd5; dst = DST_A; end
               6'd10: begin alu_op = ALU_ADD; alu_a = ra_ff; alu_b = 32'd128; dst = DST_A; end
               6'd11: begin alu_op = ALU_SDIV; alu_a = ra_ff; alu_sh = 5'd8; dst = DST_A; end
               default: kind = K_FIN;
            endcase
         end
         OP_PRESS: begin
            kind = K_ALU;
            case (step_ff)
               6'd0: begin alu_op = ALU_SDIV; alu_a = ft_ff; alu_sh = 5'd1; dst = DST_A; end
               6'd1: begin alu_op = ALU_SUB; alu_a = ra_ff; alu_b = 32'd64000; dst = DST_A; end
               6'd2: begin alu_op = ALU_SDIV; alu_a = ra_ff; alu_sh = 5'd2; dst = DST_Q; end
               6'd3: begin alu_op = ALU_MUL; alu_a = rq_ff; alu_b = rq_ff; dst = DST_Q; end
               6'd4: begin alu_op = ALU_SDIV; alu_a = rq_ff; alu_sh = 5'd11; dst = DST_B; end
               6'd5: begin alu_op = ALU_MUL; alu_a = rb_ff; alu_b = p6; dst = DST_B; end
               6'd6: begin alu_op = ALU_MUL; alu_a = ra_ff; alu_b = p5; dst = DST_C; end
               6'd7: begin alu_op = ALU_ADD; alu_a = rc_ff; alu_b = rc_ff; dst = DST_C; end
               6'd8: begin alu_op = ALU_ADD; alu_a = rb_ff; alu_b = rc_ff; dst = DST_B; end
               6'd9: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd2; dst = DST_B; end
               6'd10: begin alu_op = ALU_MUL; alu_a = p4; alu_b = 32'd65536; dst = DST_C; end
               6'd11: begin alu_op = ALU_ADD; alu_a = rb_ff; alu_b = rc_ff; dst = DST_B; end
               6'd12: begin alu_op = ALU_SDIV; alu_a = rq_ff; alu_sh = 5'd13; dst = DST_C; end
               6'd13: begin alu_op = ALU_MUL; alu_a = p3; alu_b = rc_ff; dst = DST_C; end
               6'd14: begin alu_op = ALU_SDIV; alu_a = rc_ff; alu_sh = 5'd3; dst = DST_C; end
               6'd15: begin alu_op = ALU_MUL; alu_a = p2; alu_b = ra_ff; dst = DST_D; end
               6'd16: begin alu_op = ALU_SDIV; alu_a = rd_ff; alu_sh = 5'd1; dst = DST_D; end
               6'd17: begin alu_op = ALU_ADD; alu_a = rc_ff; alu_b = rd_ff; dst = DST_A; end
               6'd18: begin alu_op = ALU_SDIV; alu_a = ra_ff; alu_sh = 5'd18; dst = DST_A; end
               6'd19: begin alu_op = ALU_ADD; alu_a = ra_ff; alu_b = 32'd32768; dst = DST_A; end
               6'd20: begin alu_op = ALU_MUL; alu_a = ra_ff; alu_b = p1; dst = DST_A; end
               6'd21: begin alu_op = ALU_SDIV; alu_a = ra_ff; alu_sh = 5'd15; dst = DST_A; end
               6'd22: kind = K_ZCHK;
               6'd23: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd12; dst = DST_C; end
               6'd24: begin alu_op = ALU_SUB; alu_a = 32'd1048576; alu_b = {12'b0, raw_ff};
                  dst = DST_D; end
               6'd25: begin alu_op = ALU_SUB; alu_a = rd_ff; alu_b = rc_ff; dst = DST_D; end
               6'd26: begin alu_op = ALU_MUL; alu_a = rd_ff; alu_b = 32'd3125; dst = DST_P; end
               6'd27: kind = K_DIV;
               6'd28: begin alu_op = ALU_USHR; alu_a = rp_ff; alu_sh = 5'd3; dst = DST_E; end
               6'd29: begin alu_op = ALU_MUL; alu_a = re_ff; alu_b = re_ff; dst = DST_E; end
               6'd30: begin alu_op = ALU_USHR; alu_a = re_ff; alu_sh = 5'd13; dst = DST_E; end
               6'd31: begin alu_op = ALU_MUL; alu_a = p9; alu_b = re_ff; dst = DST_A; end
               6'd32: begin alu_op = ALU_SDIV; alu_a = ra_ff; alu_sh = 5'd12; dst = DST_A; end
               6'd33: begin alu_op = ALU_USHR; alu_a = rp_ff; alu_sh = 5'd2; dst = DST_B; end
               6'd34: begin alu_op = ALU_MUL; alu_a = rb_ff; alu_b = p8; dst = DST_B; end
               6'd35: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd13; dst = DST_B; end
               6'd36: begin alu_op = ALU_ADD; alu_a = ra_ff; alu_b = rb_ff; dst = DST_C; end
               6'd37: begin alu_op = ALU_ADD; alu_a = rc_ff; alu_b = p7; dst = DST_C; end
               6'd38: begin alu_op = ALU_SDIV; alu_a = rc_ff; alu_sh = 5'd4; dst = DST_C; end
               6'd39: begin alu_op = ALU_ADD; alu_a = rp_ff; alu_b = rc_ff; dst = DST_P; end
               default: kind = K_FIN;
            endcase
         end
         OP_HUM: begin
            kind = K_ALU;
            case (step_ff)
               6'd0: begin alu_op = ALU_SUB; alu_a = ft_ff; alu_b = 32'd76800; dst = DST_A; end
               6'd1: begin alu_op = ALU_MUL; alu_a = {16'b0, raw_ff[15:0]};
                  alu_b = 32'd16384; dst = DST_B; end
               6'd2: begin alu_op = ALU_MUL; alu_a = h4; alu_b = 32'd1048576; dst = DST_C; end
               6'd3: begin alu_op = ALU_SUB; alu_a = rb_ff; alu_b = rc_ff; dst = DST_B; end
               6'd4: begin alu_op = ALU_MUL; alu_a = h5; alu_b = ra_ff; dst = DST_D; end
               6'd5: begin alu_op = ALU_SUB; alu_a = rb_ff; alu_b = rd_ff; dst = DST_B; end
               6'd6: begin alu_op = ALU_ADD; alu_a = rb_ff; alu_b = 32'd16384; dst = DST_B; end
               6'd7: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd15; dst = DST_E; end
               6'd8: begin alu_op = ALU_MUL; alu_a = ra_ff; alu_b = h6; dst = DST_B; end
               6'd9: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd10; dst = DST_B; end
               6'd10: begin alu_op = ALU_MUL; alu_a = ra_ff; alu_b = h3; dst = DST_C; end
               6'd11: begin alu_op = ALU_SDIV; alu_a = rc_ff; alu_sh = 5'd11; dst = DST_C; end
               6'd12: begin alu_op = ALU_ADD; alu_a = rc_ff; alu_b = 32'd32768; dst = DST_C; end
               6'd13: begin alu_op = ALU_MUL; alu_a = rb_ff; alu_b = rc_ff; dst = DST_B; end
               6'd14: begin alu_op = ALU_SDIV; alu_a = rb_ff; alu_sh = 5'd10; dst = DST_B; end
               6'd15: begin alu_op = ALU_ADD; alu_a = rb_ff; alu_b = 32'd2097152; dst = DST_D; end
               6'd16: begin alu_op = ALU_MUL; alu_a = rd_ff; alu_b = h2; dst = DST_D; end
               6'd17: begin alu_op = ALU_ADD; alu_a = rd_ff; alu_b = 32'd8192; dst = DST_D; end
               6'd18: begin alu_op = ALU_SDIV; alu_a = rd_ff; alu_sh = 5'd14; dst = DST_B; end
               6'd19: begin alu_op = ALU_MUL; alu_a = re_ff; alu_b = rb_ff; dst = DST_C; end
               6'd20: begin alu_op = ALU_SDIV; alu_a = rc_ff; alu_sh = 5'd15; dst = DST_D; end
               6'd21: begin alu_op = ALU_MUL; alu_a = rd_ff; alu_b = rd_ff; dst = DST_D; end
               6'd22: begin alu_op = ALU_SDIV; alu_a = rd_ff; alu_sh = 5'd7; dst = DST_D; end
               6'd23: begin alu_op = ALU_MUL; alu_a = rd_ff; alu_b = h1; dst = DST_D; end
               6'd24: begin alu_op = ALU_SDIV; alu_a = rd_ff; alu_sh = 5'd4; dst = DST_D; end
               6'd25: begin alu_op = ALU_SUB; alu_a = rc_ff; alu_b = rd_ff; dst = DST_E; end
               default: kind = K_FIN;
            endcase
         end
         default: kind = K_FIN;
      endcase
   end

   // Shared arithmetic unit. Signed division by a power of two truncates toward zero,
   // so negative operands are biased before the arithmetic shift.
   always_comb begin
      mul_full  = {32'b0, alu_a} * {32'b0, alu_b};
      sdiv_bias = alu_a[31] ? ((32'd1 << alu_sh) - 32'd1) : 32'd0;
      case (alu_op)
         ALU_ADD:  alu_res = alu_a + alu_b;
         ALU_SUB:  alu_res = alu_a - alu_b;
         ALU_MUL:  alu_res = mul_full[31:0];
         ALU_SDIV: alu_res = 32'($signed(alu_a + sdiv_bias) >>> alu_sh);
         ALU_USHR: alu_res = alu_a >> alu_sh;
         default:  alu_res = '0;
      endcase
   end

   // Final clamping of the result for each quantity.
   always_comb begin
      hum_clip = '0;
      case (op_ff)
         OP_TEMP: begin
            if ($signed(ra_ff) < -32'sd4000) fin_value = 32'hFFFF_F060;
            else if ($signed(ra_ff) > 32'sd8500) fin_value = 32'd8500;
            else fin_value = ra_ff;
         end
         OP_PRESS: begin
            if (rp_ff < 32'd30000) fin_value = 32'd30000;
            else if (rp_ff > 32'd110000) fin_value = 32'd110000;
            else fin_value = rp_ff;
         end
         OP_HUM: begin
            if (re_ff[31]) hum_clip = '0;
            else if (re_ff > 32'd419430400) hum_clip = 32'd419430400;
            else hum_clip = re_ff;
            fin_value = hum_clip >> 12;
            if (fin_value > 32'd102400) fin_value = 32'd102400;
         end
         default: fin_value = '0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign div_start = (state_ff == ST_RUN) && (kind == K_DIV);

   escu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rp_ff[31] ? rp_ff : {rp_ff[30:0], 1'b0}),
      .divisor  (ra_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            case (kind)
               K_ALU: step_in = step_ff + 6'd1;
               K_DIV: state_in = ST_DIVW;
               K_ZCHK: begin
                  if (ra_ff != 32'd0) step_in = step_ff + 6'd1;
                  else if (out_free) state_in = ST_IDLE;
               end
               K_FIN: if (out_free) state_in = ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_DIVW: begin
            if (div_done) begin
               state_in = ST_RUN;
               step_in  = step_ff + 6'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         ft_ff          <= '0;
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
         cal_hum_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_TEMP:    cal_temp_ff    <= csr_data[47:0];
               CSR_PRESS_A: cal_press_a_ff <= csr_data;
               CSR_PRESS_B: cal_press_b_ff <= csr_data;
               CSR_PRESS_C: cal_press_c_ff <= csr_data[15:0];
               CSR_HUM:     cal_hum_ff     <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ST_RUN && kind == K_ALU && dst == DST_FT) ft_ff <= alu_res;
         if (state_ff == ST_RUN && out_free &&
             (kind == K_FIN || (kind == K_ZCHK && ra_ff == 32'd0))) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff  <= req_tuser;
         raw_ff <= req_tdata[19:0];
      end
      if (state_ff == ST_RUN && kind == K_ALU) begin
         case (dst)
            DST_A: ra_ff <= alu_res;
            DST_B: rb_ff <= alu_res;
            DST_C: rc_ff <= alu_res;
            DST_D: rd_ff <= alu_res;
            DST_E: re_ff <= alu_res;
            DST_P: rp_ff <= alu_res;
            DST_Q: rq_ff <= alu_res;
            default: ;
         endcase
      end
      // Large dividends were halved in effect, so the quotient is doubled back.
      if (state_ff == ST_DIVW && div_done) begin
         rp_ff <= rp_ff[31] ? {div_quot[30:0], 1'b0} : div_quot;
      end
      if (state_ff == ST_RUN && out_free) begin
         if (kind == K_FIN) begin
            rsp_value_ff <= fin_value[17:0];
            rsp_qty_ff   <= op_ff;
            rsp_fault_ff <= 1'b0;
         end else if (kind == K_ZCHK && ra_ff == 32'd0) begin
            rsp_value_ff <= 18'd30000;
            rsp_qty_ff   <= op_ff;
            rsp_fault_ff <= 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_value_ff};
   assign rsp_tuser  = {rsp_fault_ff, rsp_qty_ff};

   `ESCU_ASSERT_NXT(a_accept_runs, req_tvalid && req_tready, state_ff == ST_RUN)
   `ESCU_ASSERT_IMP(a_div_in_wait, div_busy, state_ff == ST_DIVW)
   `ESCU_ASSERT_IMP(a_fault_press, rsp_valid_ff && rsp_fault_ff, rsp_qty_ff == OP_PRESS)

endmodule

// ===== src/escu_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on escu_pkg for the data width.
module escu_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [escu_pkg::DataWidth-1:0] dividend,
   input  logic [escu_pkg::DataWidth-1:0] divisor,
   output logic                           busy,
   output logic                           done,
   output logic [escu_pkg::DataWidth-1:0] quotient
);
   import escu_pkg::*;

   logic [DataWidth:0]   rem_ff, rem_in;
   logic [DataWidth-1:0] quo_ff, quo_in;
   logic [DataWidth-1:0] dsr_ff, dsr_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DataWidth:0]   shifted;
   logic [DataWidth:0]   diff;

   always_comb begin
      shifted = {rem_ff[DataWidth-1:0], quo_ff[DataWidth-1]};
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = 6'(DataWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DataWidth]) begin
            rem_in = diff;
            quo_in = {quo_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DataWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
